/* design/hftf_pkg.sv */
// ----------------------------------------------------------------------------
// hftf_pkg: shared types and constants for the hex float text formatter
// Character codes, field widths, the emitter state type and the status word
// of the serial exponent converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hftf_pkg;

  // field and datapath widths
  localparam int unsigned RawW   = 64;
  localparam int unsigned CharW  = 7;
  localparam int unsigned MantW  = 52;
  localparam int unsigned MagW   = 11;
  localparam int unsigned BcdDig = 4;
  localparam int unsigned BcdW   = 4 * BcdDig;
  localparam int unsigned CntW   = $clog2(MagW + 1);
  localparam int unsigned DigIdxW = $clog2(BcdDig);

  // IEEE layout constants
  localparam logic [10:0] DblExpMax = 11'h7FF;
  localparam logic [10:0] DblBias   = 11'd1023;
  localparam logic [10:0] DblSubExp = 11'd1022;
  localparam logic [10:0] SglExpMax = 11'h0FF;
  localparam logic [10:0] SglBias   = 11'd127;
  localparam logic [10:0] SglSubExp = 11'd126;

  // ASCII codes
  localparam logic [CharW-1:0] ChMinus = 7'h2D;
  localparam logic [CharW-1:0] ChPlus  = 7'h2B;
  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChOne   = 7'h31;
  localparam logic [CharW-1:0] ChX     = 7'h78;
  localparam logic [CharW-1:0] ChDot   = 7'h2E;
  localparam logic [CharW-1:0] ChP     = 7'h70;
  localparam logic [CharW-1:0] ChI     = 7'h69;
  localparam logic [CharW-1:0] ChN     = 7'h6E;
  localparam logic [CharW-1:0] ChF     = 7'h66;
  localparam logic [CharW-1:0] ChLowA  = 7'h61;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIGN,
    ST_ZERO,
    ST_X,
    ST_LEAD,
    ST_DOT,
    ST_MANT,
    ST_P,
    ST_ESIGN,
    ST_EDIG,
    ST_INF_I,
    ST_INF_N,
    ST_INF_F
  } fmt_state_e;

  // status of the serial exponent converter
  typedef struct packed {
    logic                done;
    logic [DigIdxW-1:0]  top_idx;
    logic [BcdW-1:0]     bcd;
  } bcd_res_t;

  // status of the mantissa digit shifter
  typedef struct packed {
    logic       all_zero;
    logic       rest_zero;
    logic [3:0] digit;
  } mant_res_t;

  // lower-case hex digit to ASCII
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] d);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = ChZero + {3'b000, d};
    end else begin
      c = ChLowA + {3'b000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/hftf_bcd.sv */
// ----------------------------------------------------------------------------
// hftf_bcd: serial binary to decimal converter for the exponent
// Shift-and-add-3 conversion, one magnitude bit per cycle, four BCD digits.
// ----------------------------------------------------------------------------
`default_nettype none

module hftf_bcd (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [hftf_pkg::MagW-1:0] mag_i,
  output hftf_pkg::bcd_res_t         res_o
);
  import hftf_pkg::*;

  logic [MagW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [BcdW-1:0] adj;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BcdDig; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // load on start, then shift one bit per cycle
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = CntW'(MagW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d  = {adj[BcdW-2:0], bin_q[MagW-1]};
      bin_d  = {bin_q[MagW-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // highest nonzero digit; a zero magnitude still shows one digit
  always_comb begin
    res_o.done = !busy_q;
    res_o.bcd  = bcd_q;
    priority if (bcd_q[15:12] != 4'd0) begin
      res_o.top_idx = DigIdxW'(3);
    end else if (bcd_q[11:8] != 4'd0) begin
      res_o.top_idx = DigIdxW'(2);
    end else if (bcd_q[7:4] != 4'd0) begin
      res_o.top_idx = DigIdxW'(1);
    end else begin
      res_o.top_idx = DigIdxW'(0);
    end
  end

endmodule

`default_nettype wire

/* design/hftf_mshift.sv */
// ----------------------------------------------------------------------------
// hftf_mshift: mantissa digit shifter
// Holds the mantissa left aligned and moves it out one hex digit per cycle while shift_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module hftf_mshift (
  input  wire logic                       clk_i,
  input  wire logic                       load_i,
  input  wire logic [hftf_pkg::MantW-1:0] mant_i,
  input  wire logic                       shift_i,
  output hftf_pkg::mant_res_t             res_o
);
  import hftf_pkg::*;

  logic [MantW-1:0] mant_q, mant_d;

  // load a new mantissa or drop the top digit
  always_comb begin
    mant_d = mant_q;
    if (load_i) begin
      mant_d = mant_i;
    end else if (shift_i) begin
      mant_d = {mant_q[MantW-5:0], 4'h0};
    end
  end

  always_ff @(posedge clk_i) begin
    mant_q <= mant_d;
  end

  assign res_o.digit     = mant_q[MantW-1 -: 4];
  assign res_o.rest_zero = (mant_q[MantW-5:0] == '0);
  assign res_o.all_zero  = (mant_q == '0);

endmodule

`default_nettype wire

/* design/hex_float_text_formatter.sv */
// ----------------------------------------------------------------------------
// hex_float_text_formatter: IEEE value to hexadecimal text
// Emits the "%a"-style text of a binary64 or binary32 value as ASCII words.
// ----------------------------------------------------------------------------
// One value enters per input word (tdata = raw bits, tuser = 1 for binary32)
// and leaves as one ASCII character per output word, tlast on the final
// character; a NaN is taken and produces no words. The input is taken only
// while no text is being produced, so a value occupies the block until its
// last character has been handed to an output register in front of the
// output channel. The decimal exponent comes from a bit-serial converter
// started when the value is taken; the exponent sign waits for it.
`default_nettype none

module hex_float_text_formatter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] raw_bits
  input  wire logic        s_axis_tuser,   // [0] is_single
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [6:0] char_code, [7] zero pad
  output      logic        m_axis_tlast    // last_char
);
  import hftf_pkg::*;

  fmt_state_e state_q, state_d;

  logic             is_inf_q, mant_nz_q, lead_one_q, eneg_q;
  logic [DigIdxW-1:0] dig_idx_q, dig_idx_d;

  logic             accept;
  logic             in_neg, in_inf, in_nan, in_mnz, in_lead, in_eneg;
  logic [10:0]      in_exp, in_bias, in_max, in_sub;
  logic [MagW-1:0]  in_mag;
  logic [MantW-1:0] in_mant;

  logic             emit, out_free, have_char, char_last;
  logic [CharW-1:0] char_d;
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q;

  bcd_res_t  bcd_res;
  mant_res_t mant_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  // decode the incoming value
  always_comb begin
    if (s_axis_tuser) begin
      in_neg  = s_axis_tdata[31];
      in_exp  = {3'b000, s_axis_tdata[30:23]};
      in_mnz  = (s_axis_tdata[22:0] != '0);
      in_mant = {s_axis_tdata[22:0], 1'b0, 28'h0};
      in_bias = SglBias;
      in_max  = SglExpMax;
      in_sub  = SglSubExp;
    end else begin
      in_neg  = s_axis_tdata[63];
      in_exp  = s_axis_tdata[62:52];
      in_mnz  = (s_axis_tdata[51:0] != '0);
      in_mant = s_axis_tdata[51:0];
      in_bias = DblBias;
      in_max  = DblExpMax;
      in_sub  = DblSubExp;
    end
    in_inf  = (in_exp == in_max) && !in_mnz;
    in_nan  = (in_exp == in_max) && in_mnz;
    in_lead = (in_exp != 11'd0);
    if (in_exp == 11'd0) begin
      in_eneg = in_mnz;
      in_mag  = in_mnz ? in_sub : '0;
    end else if (in_exp >= in_bias) begin
      in_eneg = 1'b0;
      in_mag  = in_exp - in_bias;
    end else begin
      in_eneg = 1'b1;
      in_mag  = in_bias - in_exp;
    end
  end

  hftf_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .mag_i   (in_mag),
    .res_o   (bcd_res)
  );

  hftf_mshift u_mshift (
    .clk_i   (clk_i),
    .load_i  (accept),
    .mant_i  (in_mant),
    .shift_i (emit && (state_q == ST_MANT)),
    .res_o   (mant_res)
  );

  // the output register takes a word when empty or being drained
  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit          = out_free && have_char;
  assign s_axis_tready = (state_q == ST_IDLE);

  // next state and the character of the current state
  always_comb begin
    state_d   = state_q;
    dig_idx_d = dig_idx_q;
    have_char = 1'b1;
    char_last = 1'b0;
    char_d    = ChZero;
    unique case (state_q)
      ST_IDLE: begin
        have_char = 1'b0;
        if (accept && !in_nan) begin
          if (in_neg) begin
            state_d = ST_SIGN;
          end else if (in_inf) begin
            state_d = ST_INF_I;
          end else begin
            state_d = ST_ZERO;
          end
        end
      end
      ST_SIGN: begin
        char_d = ChMinus;
        if (emit) begin
          state_d = is_inf_q ? ST_INF_I : ST_ZERO;
        end
      end
      ST_ZERO: begin
        char_d = ChZero;
        if (emit) begin
          state_d = ST_X;
        end
      end
      ST_X: begin
        char_d = ChX;
        if (emit) begin
          state_d = ST_LEAD;
        end
      end
      ST_LEAD: begin
        char_d = lead_one_q ? ChOne : ChZero;
        if (emit) begin
          state_d = mant_nz_q ? ST_DOT : ST_P;
        end
      end
      ST_DOT: begin
        char_d = ChDot;
        if (emit) begin
          state_d = ST_MANT;
        end
      end
      ST_MANT: begin
        char_d = hex_char(mant_res.digit);
        if (emit && mant_res.rest_zero) begin
          state_d = ST_P;
        end
      end
      ST_P: begin
        char_d = ChP;
        if (emit) begin
          state_d = ST_ESIGN;
        end
      end
      ST_ESIGN: begin
        // hold the sign until the converter has finished, so the top digit is known
        have_char = bcd_res.done;
        char_d    = eneg_q ? ChMinus : ChPlus;
        if (emit) begin
          state_d   = ST_EDIG;
          dig_idx_d = bcd_res.top_idx;
        end
      end
      ST_EDIG: begin
        // hold until the converter has finished
        have_char = bcd_res.done;
        char_d    = ChZero + {3'b000, bcd_res.bcd[4*dig_idx_q +: 4]};
        char_last = (dig_idx_q == '0);
        if (emit) begin
          if (dig_idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            dig_idx_d = dig_idx_q - 1'b1;
          end
        end
      end
      ST_INF_I: begin
        char_d = ChI;
        if (emit) begin
          state_d = ST_INF_N;
        end
      end
      ST_INF_N: begin
        char_d = ChN;
        if (emit) begin
          state_d = ST_INF_F;
        end
      end
      ST_INF_F: begin
        char_d    = ChF;
        char_last = 1'b1;
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        have_char = 1'b0;
        state_d   = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dig_idx_q   <= '0;
    end else begin
      state_q   <= state_d;
      dig_idx_q <= dig_idx_d;
      if (out_free) begin
        out_valid_q <= have_char;
      end
    end
  end

  // capture per-value flags and the output word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_inf_q   <= in_inf;
      mant_nz_q  <= in_mnz;
      lead_one_q <= in_lead;
      eneg_q     <= in_eneg;
    end
    if (emit) begin
      out_char_q <= char_d;
      out_last_q <= char_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;

  // no word is produced while waiting for a value
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("word produced from idle");

  // exponent digits leave only after the converter finished
  a_edig_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EDIG && emit) |-> bcd_res.done)
    else $error("exponent digit before conversion done");

  // the mantissa run never reaches an all-zero shifter
  a_mant_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MANT) |-> !mant_res.all_zero)
    else $error("mantissa digits past last nonzero digit");

  // the final character returns the emitter to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && char_last) |=> (state_q == ST_IDLE))
    else $error("last character without return to idle");

endmodule

`default_nettype wire
